// File: design/tsrr_pkg.sv
// package for the task slot round robin scheduler
// holds operation, status, slot state, controller state and walk op codes and the controller/datapath structs
// no dependencies
package tsrr_pkg;

    typedef enum logic [3:0] {
        OP_CREATE        = 4'd0,
        OP_EXIT          = 4'd1,
        OP_KILL          = 4'd2,
        OP_SCHEDULE      = 4'd3,
        OP_REAP          = 4'd4,
        OP_PE_ON         = 4'd5,
        OP_PE_OFF        = 4'd6,
        OP_RESCHED       = 4'd7,
        OP_PREEMPT_CHECK = 4'd8
    } op_t;

    typedef enum logic [1:0] {
        RS_OK      = 2'd0,
        RS_NO_FREE = 2'd1,
        RS_NO_TASK = 2'd2,
        RS_NO_RUN  = 2'd3
    } res_status_t;

    typedef enum logic [1:0] {
        ST_FREE   = 2'd0,
        ST_RUN    = 2'd1,
        ST_ZOMBIE = 2'd2
    } slot_state_t;

    typedef enum logic [3:0] {
        CS_IDLE,
        CS_DISPATCH,
        CS_CREATE,
        CS_EXIT,
        CS_KILL,
        CS_FLAG,
        CS_SCAN,
        CS_CLR_PREV,
        CS_SET_CAND,
        CS_REAP,
        CS_FINISH
    } ctrl_state_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_ONE,
        IDX_INC,
        IDX_CUR,
        IDX_CUR_INC,
        IDX_TGT,
        IDX_CAND
    } idx_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_ONE,
        CNT_INC
    } cnt_op_t;

    typedef struct packed {
        logic        load;
        idx_op_t     idx_op;
        cnt_op_t     cnt_op;
        logic        wr_st;
        slot_state_t st_val;
        logic        wr_pe;
        logic        pe_val;
        logic        wr_ns;
        logic        ns_val;
        logic        set_status;
        res_status_t status_val;
        logic        take_cand;
        logic        mark_created;
        logic        commit_cur;
        logic        reap_inc;
        logic        out_load;
    } dp_cmd_t;

    typedef struct packed {
        op_t         op;
        slot_state_t rd_st;
        logic        rd_pe;
        logic        rd_ns;
        logic        idx_last;
        logic        scan_last;
        logic        tgt_ok;
        logic        out_busy;
    } dp_stat_t;

endpackage

// File: design/tsrr_dp.sv
// datapath of the task slot round robin scheduler: slot table, current slot,
// walk index and the result register
// depends on tsrr_pkg
module tsrr_dp #(
    parameter int SLOT_COUNT = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tsrr_pkg::dp_cmd_t cmd,
    output tsrr_pkg::dp_stat_t stat,
    input  logic [7:0]        s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata
);
    import tsrr_pkg::*;

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam logic [SW-1:0] LAST_IDX = SW'(SLOT_COUNT - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(SLOT_COUNT);

    slot_state_t st_reg [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] pe_reg;
    logic [SLOT_COUNT-1:0] ns_reg;

    op_t         op_reg;
    logic [3:0]  tgt_reg;
    logic [SW-1:0] idx_reg, idx_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [SW-1:0] cand_reg;
    logic [SW-1:0] cur_reg;
    logic [SW-1:0] new_reg;
    logic          created_reg;
    logic          moved_reg;
    res_status_t   status_reg;
    logic [SW-1:0] reaped_reg;
    logic          out_valid_reg;
    logic [15:0]   out_data_reg;

    logic [SW-1:0] idx_inc;
    logic [SW-1:0] cur_inc;

    assign idx_inc = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
    assign cur_inc = (cur_reg == LAST_IDX) ? '0 : cur_reg + 1'b1;

    always_comb
    begin
        case (cmd.idx_op)
            IDX_HOLD:    idx_next = idx_reg;
            IDX_ZERO:    idx_next = '0;
            IDX_ONE:     idx_next = SW'(1);
            IDX_INC:     idx_next = idx_inc;
            IDX_CUR:     idx_next = cur_reg;
            IDX_CUR_INC: idx_next = cur_inc;
            IDX_TGT:     idx_next = SW'(tgt_reg);
            IDX_CAND:    idx_next = cand_reg;
            default:     idx_next = idx_reg;
        endcase
        case (cmd.cnt_op)
            CNT_HOLD: cnt_next = cnt_reg;
            CNT_ONE:  cnt_next = CW'(1);
            CNT_INC:  cnt_next = cnt_reg + 1'b1;
            default:  cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                st_reg[i] <= (i == 0) ? ST_RUN : ST_FREE;
            end
            pe_reg        <= SLOT_COUNT'(1);
            ns_reg        <= '0;
            cur_reg       <= '0;
            op_reg        <= OP_CREATE;
            tgt_reg       <= '0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            cand_reg      <= '0;
            new_reg       <= '0;
            created_reg   <= 1'b0;
            moved_reg     <= 1'b0;
            status_reg    <= RS_OK;
            reaped_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
            if (cmd.load)
            begin
                op_reg      <= op_t'(s_tdata[3:0]);
                tgt_reg     <= s_tdata[7:4];
                status_reg  <= RS_OK;
                created_reg <= 1'b0;
                moved_reg   <= 1'b0;
                reaped_reg  <= '0;
            end
            if (cmd.wr_st)
            begin
                st_reg[idx_reg] <= cmd.st_val;
            end
            if (cmd.wr_pe)
            begin
                pe_reg[idx_reg] <= cmd.pe_val;
            end
            if (cmd.wr_ns)
            begin
                ns_reg[idx_reg] <= cmd.ns_val;
            end
            if (cmd.set_status)
            begin
                status_reg <= cmd.status_val;
            end
            if (cmd.take_cand)
            begin
                cand_reg <= idx_reg;
            end
            if (cmd.mark_created)
            begin
                created_reg <= 1'b1;
                new_reg     <= idx_reg;
            end
            if (cmd.commit_cur)
            begin
                cur_reg   <= idx_reg;
                moved_reg <= (idx_reg != cur_reg);
            end
            if (cmd.reap_inc)
            begin
                reaped_reg <= reaped_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= {4'b0000, 5'(reaped_reg), moved_reg,
                                  created_reg ? 4'(new_reg) : 4'(cur_reg), status_reg};
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.op        = op_reg;
    assign stat.rd_st     = st_reg[idx_reg];
    assign stat.rd_pe     = pe_reg[idx_reg];
    assign stat.rd_ns     = ns_reg[idx_reg];
    assign stat.idx_last  = (idx_reg == LAST_IDX);
    assign stat.scan_last = (cnt_reg == CNT_FULL);
    assign stat.tgt_ok    = (32'(tgt_reg) < 32'(SLOT_COUNT));
    assign stat.out_busy  = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: design/tsrr_ctrl.sv
// controller of the task slot round robin scheduler: sequences each operation
// over the slot table, one slot access per cycle
// depends on tsrr_pkg
module tsrr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output tsrr_pkg::dp_cmd_t  cmd,
    input  tsrr_pkg::dp_stat_t stat
);
    import tsrr_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            CS_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = CS_DISPATCH;
                end
            end
            CS_DISPATCH:
            begin
                case (stat.op)
                    OP_CREATE:
                    begin
                        cmd.idx_op = IDX_ZERO;
                        state_next = CS_CREATE;
                    end
                    OP_EXIT:
                    begin
                        cmd.idx_op = IDX_CUR;
                        state_next = CS_EXIT;
                    end
                    OP_KILL:
                    begin
                        if (stat.tgt_ok)
                        begin
                            cmd.idx_op = IDX_TGT;
                            state_next = CS_KILL;
                        end
                        else
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status_val = RS_NO_TASK;
                            state_next     = CS_FINISH;
                        end
                    end
                    OP_SCHEDULE:
                    begin
                        cmd.idx_op = IDX_CUR_INC;
                        cmd.cnt_op = CNT_ONE;
                        state_next = CS_SCAN;
                    end
                    OP_REAP:
                    begin
                        cmd.idx_op = IDX_ONE;
                        state_next = CS_REAP;
                    end
                    OP_PE_ON, OP_PE_OFF, OP_RESCHED, OP_PREEMPT_CHECK:
                    begin
                        cmd.idx_op = IDX_CUR;
                        state_next = CS_FLAG;
                    end
                    default:
                    begin
                        state_next = CS_FINISH;
                    end
                endcase
            end
            CS_CREATE:
            begin
                if (stat.rd_st == ST_FREE)
                begin
                    cmd.wr_st        = 1'b1;
                    cmd.st_val       = ST_RUN;
                    cmd.wr_pe        = 1'b1;
                    cmd.pe_val       = 1'b1;
                    cmd.wr_ns        = 1'b1;
                    cmd.ns_val       = 1'b0;
                    cmd.mark_created = 1'b1;
                    state_next       = CS_FINISH;
                end
                else if (stat.idx_last)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status_val = RS_NO_FREE;
                    state_next     = CS_FINISH;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                end
            end
            CS_EXIT:
            begin
                cmd.wr_st  = 1'b1;
                cmd.st_val = ST_ZOMBIE;
                cmd.idx_op = IDX_CUR_INC;
                cmd.cnt_op = CNT_ONE;
                state_next = CS_SCAN;
            end
            CS_KILL:
            begin
                if (stat.rd_st != ST_FREE)
                begin
                    cmd.wr_st  = 1'b1;
                    cmd.st_val = ST_FREE;
                    cmd.wr_pe  = 1'b1;
                    cmd.wr_ns  = 1'b1;
                end
                else
                begin
                    cmd.set_status = 1'b1;
                    cmd.status_val = RS_NO_TASK;
                end
                state_next = CS_FINISH;
            end
            CS_FLAG:
            begin
                state_next = CS_FINISH;
                case (stat.op)
                    OP_PE_ON:
                    begin
                        cmd.wr_pe  = 1'b1;
                        cmd.pe_val = 1'b1;
                    end
                    OP_PE_OFF:
                    begin
                        cmd.wr_pe  = 1'b1;
                    end
                    OP_RESCHED:
                    begin
                        cmd.wr_ns  = 1'b1;
                        cmd.ns_val = 1'b1;
                    end
                    OP_PREEMPT_CHECK:
                    begin
                        if (stat.rd_pe && stat.rd_ns)
                        begin
                            cmd.wr_ns  = 1'b1;
                            cmd.idx_op = IDX_CUR_INC;
                            cmd.cnt_op = CNT_ONE;
                            state_next = CS_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = CS_FINISH;
                    end
                endcase
            end
            CS_SCAN:
            begin
                if (stat.rd_st == ST_RUN)
                begin
                    cmd.take_cand = 1'b1;
                    cmd.idx_op    = IDX_CUR;
                    state_next    = CS_CLR_PREV;
                end
                else if (stat.scan_last)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status_val = RS_NO_RUN;
                    state_next     = CS_FINISH;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                    cmd.cnt_op = CNT_INC;
                end
            end
            CS_CLR_PREV:
            begin
                cmd.wr_pe  = 1'b1;
                cmd.idx_op = IDX_CAND;
                state_next = CS_SET_CAND;
            end
            CS_SET_CAND:
            begin
                cmd.wr_pe      = 1'b1;
                cmd.pe_val     = 1'b1;
                cmd.commit_cur = 1'b1;
                state_next     = CS_FINISH;
            end
            CS_REAP:
            begin
                if (stat.rd_st == ST_ZOMBIE)
                begin
                    cmd.wr_st    = 1'b1;
                    cmd.st_val   = ST_FREE;
                    cmd.wr_pe    = 1'b1;
                    cmd.wr_ns    = 1'b1;
                    cmd.reap_inc = 1'b1;
                end
                if (stat.idx_last)
                begin
                    state_next = CS_FINISH;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                end
            end
            CS_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

endmodule

// File: design/task_slot_round_robin_scheduler.sv
// top level of the task slot round robin scheduler; one beat in, one beat out
// from input beat to result beat: unused codes go from dispatch straight to the result, flag and kill touch
// one slot, and create, reap, schedule, exit and preempt check walk the slot table
// one operation in flight: the next beat is taken the cycle after the result loads
// rst_n asynchronous active low: slot 0 running and preemptible, others free
// depends on tsrr_pkg, tsrr_ctrl, tsrr_dp
module task_slot_round_robin_scheduler #(
    parameter int SLOT_COUNT = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // operation[3:0], target_slot[7:4]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // status[1:0], result_slot[5:2], switched[6], reaped_count[11:7]
);
    import tsrr_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    tsrr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    tsrr_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: design/tsrr_checker.sv
// port checker for the task slot round robin scheduler, bound to the top level
// depends on task_slot_round_robin_scheduler
module tsrr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // one operation at a time
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat taken while busy");

    // a slot switch only comes with ok status
    a_switch_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[6] |-> m_tdata[1:0] == 2'd0)
        else $error("switch reported with error status");

    // reaping never switches and never fails
    a_reap_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[11:7] != 5'd0 |-> m_tdata[1:0] == 2'd0 && !m_tdata[6])
        else $error("reap count with switch or error");

    // padding stays zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:12] == 4'd0)
        else $error("nonzero padding in result beat");

endmodule

bind task_slot_round_robin_scheduler tsrr_checker u_tsrr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/sv/testbench.sv
// testbench for task_slot_round_robin_scheduler: directed and random operation beats with
// random idling on both sides, checked against a behavioral model of the slot table
// depends on tsrr_pkg and task_slot_round_robin_scheduler
`timescale 1ns / 1ps

module testbench;
    import tsrr_pkg::*;

    localparam int SLOT_COUNT = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 250;
    localparam int MAX_REPORTS = 10;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_PREEMPT,
        MIX_ANY
    } op_mix_t;

    typedef struct {
        logic [1:0] status;
        logic [3:0] slot;
        logic       switched;
        logic [4:0] reaped;
    } sched_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // operation[3:0], target_slot[7:4]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // status[1:0], result_slot[5:2], switched[6], reaped_count[11:7]

    slot_state_t   slot_tbl [SLOT_COUNT];
    bit            pe_tbl [SLOT_COUNT];
    bit            ns_tbl [SLOT_COUNT];
    int            cur_slot;

    logic [7:0]    op_beat_q [$];
    sched_result_t result_q [$];

    bit in_taken = 1'b0;
    bit out_taken = 1'b0;
    int tx_gap = 0;
    int tx_calm = 0;
    int rx_stall = 0;
    int rx_calm = 0;
    int hold_left = 0;
    int hold_count = 0;
    int results_seen = 0;
    int error_count = 0;
    int cycle_count = 0;

    task_slot_round_robin_scheduler #(
        .SLOT_COUNT(SLOT_COUNT)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            calm = $urandom_range(10, 40);
        return $urandom_range(0, 12);
    endfunction

    function automatic bit next_running(output bit moved);
        int prev;
        int cand;
        prev = cur_slot;
        moved = 1'b0;
        for (int k = 1; k <= SLOT_COUNT; k++)
        begin
            cand = (prev + k) % SLOT_COUNT;
            if (slot_tbl[cand] == ST_RUN)
            begin
                pe_tbl[prev] = 1'b0;
                cur_slot = cand;
                pe_tbl[cand] = 1'b1;
                moved = (cand != prev);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic sched_result_t predict_op(logic [3:0] op, logic [3:0] tgt);
        sched_result_t res;
        bit moved;
        bit created;
        int new_slot;
        int cur;
        moved = 1'b0;
        created = 1'b0;
        new_slot = 0;
        cur = cur_slot;
        res.status = RS_OK;
        res.reaped = '0;
        case (op)
            OP_CREATE:
            begin
                res.status = RS_NO_FREE;
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (!created && slot_tbl[i] == ST_FREE)
                    begin
                        slot_tbl[i] = ST_RUN;
                        pe_tbl[i] = 1'b1;
                        ns_tbl[i] = 1'b0;
                        new_slot = i;
                        created = 1'b1;
                        res.status = RS_OK;
                    end
                end
            end
            OP_EXIT:
            begin
                slot_tbl[cur] = ST_ZOMBIE;
                if (!next_running(moved))
                    res.status = RS_NO_RUN;
            end
            OP_KILL:
            begin
                if (tgt < SLOT_COUNT && slot_tbl[tgt] != ST_FREE)
                begin
                    slot_tbl[tgt] = ST_FREE;
                    pe_tbl[tgt] = 1'b0;
                    ns_tbl[tgt] = 1'b0;
                end
                else
                    res.status = RS_NO_TASK;
            end
            OP_SCHEDULE:
            begin
                if (!next_running(moved))
                    res.status = RS_NO_RUN;
            end
            OP_REAP:
            begin
                for (int i = 1; i < SLOT_COUNT; i++)
                begin
                    if (slot_tbl[i] == ST_ZOMBIE)
                    begin
                        slot_tbl[i] = ST_FREE;
                        pe_tbl[i] = 1'b0;
                        ns_tbl[i] = 1'b0;
                        res.reaped = res.reaped + 1'b1;
                    end
                end
            end
            OP_PE_ON:
                pe_tbl[cur] = 1'b1;
            OP_PE_OFF:
                pe_tbl[cur] = 1'b0;
            OP_RESCHED:
                ns_tbl[cur] = 1'b1;
            OP_PREEMPT_CHECK:
            begin
                if (pe_tbl[cur] && ns_tbl[cur])
                begin
                    ns_tbl[cur] = 1'b0;
                    if (!next_running(moved))
                        res.status = RS_NO_RUN;
                end
            end
            default:
                ;
        endcase
        res.slot = created ? 4'(new_slot) : 4'(cur_slot);
        res.switched = moved;
        return res;
    endfunction

    task automatic flag_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("error at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic add_beat(logic [3:0] op, logic [3:0] tgt);
        op_beat_q.push_back({tgt, op});
    endtask

    // input beat accepted: advance the model
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            in_taken = 1'b1;
            result_q.push_back(predict_op(s_tdata[3:0], s_tdata[7:4]));
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && !(s_tvalid && !in_taken))
        begin
            in_taken = 1'b0;
            if (tx_gap > 0)
            begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end
            else if (op_beat_q.size() > 0)
            begin
                s_tdata <= op_beat_q.pop_front();
                s_tvalid <= 1'b1;
                tx_gap = draw_gap(tx_calm);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        sched_result_t exp;
        if (rst_n && m_tvalid && m_tready)
        begin
            out_taken = 1'b1;
            results_seen++;
            if (result_q.size() == 0)
                flag_error($sformatf("unexpected result beat %h", m_tdata));
            else
            begin
                exp = result_q.pop_front();
                if (m_tdata[1:0] !== exp.status || m_tdata[5:2] !== exp.slot
                    || m_tdata[6] !== exp.switched || m_tdata[11:7] !== exp.reaped)
                    flag_error($sformatf(
                        "expected status %0d slot %0d switched %0d reaped %0d, got %0d %0d %0d %0d",
                        exp.status, exp.slot, exp.switched, exp.reaped,
                        m_tdata[1:0], m_tdata[5:2], m_tdata[6], m_tdata[11:7]));
            end
        end
    end

    // receiver stalls, with two long hold-offs that back the block up
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
            begin
                out_taken = 1'b0;
                rx_stall = draw_gap(rx_calm);
            end
            if (hold_count < 2 && results_seen >= 40 + 280 * hold_count)
            begin
                hold_left = HOLD_CYCLES;
                hold_count++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (rx_stall > 0)
            begin
                rx_stall--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        op_mix_t mix;
        int run_len;
        int pick;
        logic [3:0] op;

        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            slot_tbl[i] = ST_FREE;
            pe_tbl[i] = 1'b0;
            ns_tbl[i] = 1'b0;
        end
        slot_tbl[0] = ST_RUN;
        pe_tbl[0] = 1'b1;
        cur_slot = 0;

        // fill the table, then one create too many
        for (int i = 0; i < SLOT_COUNT; i++)
            add_beat(OP_CREATE, 4'hF);
        add_beat(OP_SCHEDULE, 4'h0);
        add_beat(OP_EXIT, 4'h0);
        add_beat(OP_REAP, 4'h0);
        add_beat(OP_KILL, 4'h0);
        add_beat(OP_KILL, 4'h0);
        add_beat(OP_RESCHED, 4'h0);
        add_beat(OP_PREEMPT_CHECK, 4'h0);
        add_beat(OP_PE_OFF, 4'h0);
        add_beat(OP_RESCHED, 4'h0);
        add_beat(OP_PREEMPT_CHECK, 4'h0);
        add_beat(OP_PE_ON, 4'hF);
        add_beat(4'hF, 4'hF);

        while (op_beat_q.size() < 650)
        begin
            mix = op_mix_t'($urandom_range(0, 3));
            run_len = $urandom_range(8, 40);
            for (int n = 0; n < run_len; n++)
            begin
                pick = $urandom_range(0, 99);
                case (mix)
                    MIX_FILL:
                        op = pick < 55 ? OP_CREATE : pick < 65 ? OP_SCHEDULE :
                             pick < 72 ? OP_EXIT : pick < 80 ? OP_KILL :
                             pick < 85 ? OP_REAP : 4'($urandom_range(5, 8));
                    MIX_DRAIN:
                        op = pick < 30 ? OP_EXIT : pick < 55 ? OP_KILL :
                             pick < 65 ? OP_SCHEDULE : pick < 75 ? OP_REAP :
                             pick < 80 ? OP_CREATE : 4'($urandom_range(5, 8));
                    MIX_PREEMPT:
                        op = pick < 20 ? OP_RESCHED : pick < 30 ? OP_PE_ON :
                             pick < 38 ? OP_PE_OFF : pick < 65 ? OP_PREEMPT_CHECK :
                             pick < 75 ? OP_CREATE : pick < 85 ? OP_EXIT :
                             pick < 92 ? OP_SCHEDULE : OP_KILL;
                    default:
                        op = pick < 5 ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
                endcase
                add_beat(op, 4'($urandom_range(0, 15)));
            end
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (op_beat_q.size() > 0 || s_tvalid || result_q.size() > 0)
            @(posedge clk);
        repeat (SLOT_COUNT + 10) @(posedge clk);
        if (result_q.size() > 0)
            flag_error($sformatf("%0d results never arrived", result_q.size()));

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: task_slot_round_robin_scheduler.f
design/tsrr_pkg.sv
design/tsrr_dp.sv
design/tsrr_ctrl.sv
design/task_slot_round_robin_scheduler.sv
design/tsrr_checker.sv
tb/sv/testbench.sv
